// ===== src/beor_pkg.sv =====
// Shared types and constants for the binary erode / inner border row unit.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package beor_pkg;

    // Fixed payload widths
    localparam int PIX_W   = 64;
    localparam int WIDTH_W = 7;
    localparam int CFG_W   = 7;
    localparam int IDX_W   = 1;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    localparam logic [WIDTH_W-1:0] RESET_ROW_WIDTH = 7'd64;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_MODE      = 1'b0,
        REG_ROW_WIDTH = 1'b1
    } reg_index_t;

    // Mode codes
    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_BORDER = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] row_pixels;
        logic             last_row;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] row_result;
        logic             final_row;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/binary_erode_or_border_rows_unit.sv =====
// Top level of the binary erode / inner border row unit.
// Depends on beor_pkg, beor_row_proc and beor_out_fifo.
//
// Takes a binary image one packed row per transfer, top row first, and
// returns each row's cross-window result once the row below it has arrived;
// the bottom row (last_row set) returns its own result as well, marked by
// final_row. Mode 0 keeps a set pixel only when its four neighbours are set;
// mode 1 keeps a set pixel that has any clear neighbour. Pixels outside the
// image and bits at or above row_width (width zero acting as one) read as
// clear. A row is accepted every cycle while the result queue has room:
// it is captured in an input stage, the window logic resolves it
// combinationally and its results land in a four-entry result queue. The
// output port returns one result per cycle while out_ready is high, which
// is what limits the sustained rate when bottom rows bring two results.
// Write configuration only while no results are outstanding.
`timescale 1ns / 1ps
`default_nettype none

module binary_erode_or_border_rows_unit #(
    parameter int MAX_ROW_WIDTH = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [beor_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [beor_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire beor_pkg::in_item_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output beor_pkg::out_item_t                    out_data
);

    localparam int N = MAX_ROW_WIDTH;

    // Configuration
    logic                                mode_reg;
    logic [beor_pkg::WIDTH_W-1:0]        row_width_reg;
    logic [N-1:0]                        mask;

    // Row state
    logic [N-1:0]                        pending_row_reg;
    logic [N-1:0]                        above_row_reg;
    logic                                pending_valid_reg;

    // Input stage
    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    logic [N-1:0]                        s1_up_reg;
    logic [N-1:0]                        s1_mid_reg;
    logic [N-1:0]                        s1_down_reg;
    logic                                s1_emit_reg;
    logic                                s1_last_reg;

    logic                                in_fire;
    logic [N-1:0]                        in_row;
    logic [1:0]                          s1_count;
    logic                                s1_push;
    logic [N-1:0]                        mid_result;
    logic [N-1:0]                        down_result;
    beor_pkg::out_item_t                 item_mid;
    beor_pkg::out_item_t                 item_down;
    beor_pkg::out_item_t                 push_first;
    logic [1:0]                          push_count;
    logic [beor_pkg::CNT_W-1:0]          free_slots;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= beor_pkg::MODE_ERODE;
            row_width_reg <= beor_pkg::RESET_ROW_WIDTH;
        end
        else if (cfg_wr_en)
        begin
            unique case (beor_pkg::reg_index_t'(cfg_index))
                beor_pkg::REG_MODE:      mode_reg      <= cfg_wdata[0];
                beor_pkg::REG_ROW_WIDTH: row_width_reg <= cfg_wdata[beor_pkg::WIDTH_W-1:0];
                default:                 mode_reg      <= mode_reg;
            endcase
        end
    end

    // Column mask: width zero acts as one, anything above N as N
    always_comb
    begin
        for (int x = 0; x < N; x++)
            mask[x] = (x == 0) || (beor_pkg::WIDTH_W'(x) < row_width_reg);
    end

    assign in_row  = in_data.row_pixels[N-1:0] & mask;
    assign in_fire = in_valid && in_ready;

    // Results that the captured row releases
    assign s1_count = {1'b0, s1_emit_reg} + {1'b0, s1_last_reg};
    assign s1_push  = s1_valid_reg && (free_slots >= beor_pkg::CNT_W'(s1_count));
    assign in_ready = !s1_valid_reg || s1_push;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_push)
            s1_valid_next = 1'b0;
    end

    // Advance row state on each input transfer; clear after the bottom row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_row_reg   <= '0;
            above_row_reg     <= '0;
            pending_valid_reg <= 1'b0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (in_fire)
            begin
                if (in_data.last_row)
                begin
                    pending_row_reg   <= '0;
                    above_row_reg     <= '0;
                    pending_valid_reg <= 1'b0;
                end
                else
                begin
                    if (pending_valid_reg)
                        above_row_reg <= pending_row_reg;
                    pending_row_reg   <= in_row;
                    pending_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Capture the row triple for the window logic
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_up_reg   <= above_row_reg;
            s1_mid_reg  <= pending_row_reg;
            s1_down_reg <= in_row;
            s1_emit_reg <= pending_valid_reg;
            s1_last_reg <= in_data.last_row;
        end
    end

    beor_row_proc #(
        .N (N)
    ) u_row_proc (
        .mode        (mode_reg),
        .mask        (mask),
        .up_row      (s1_up_reg),
        .mid_row     (s1_mid_reg),
        .down_row    (s1_down_reg),
        .emit_mid    (s1_emit_reg),
        .mid_result  (mid_result),
        .down_result (down_result)
    );

    // Order results: pending row first, then bottom row
    always_comb
    begin
        item_mid.row_result  = beor_pkg::PIX_W'(mid_result);
        item_mid.final_row   = 1'b0;
        item_down.row_result = beor_pkg::PIX_W'(down_result);
        item_down.final_row  = 1'b1;
        push_first           = s1_emit_reg ? item_mid : item_down;
        push_count           = s1_push ? s1_count : 2'd0;
    end

    beor_out_fifo u_out_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push_first  (push_first),
        .push_second (item_down),
        .pop         (out_ready),
        .free_slots  (free_slots),
        .head_valid  (out_valid),
        .head_item   (out_data)
    );

endmodule

`default_nettype wire

// ===== src/beor_row_proc.sv =====
// Cross-window logic: computes the result for the pending row and for the
// bottom row of an image from one captured row triple. Uses beor_pkg.
`timescale 1ns / 1ps
`default_nettype none

module beor_row_proc #(
    parameter int N = 64
) (
    input  wire logic         mode,
    input  wire logic [N-1:0] mask,
    input  wire logic [N-1:0] up_row,
    input  wire logic [N-1:0] mid_row,
    input  wire logic [N-1:0] down_row,
    input  wire logic         emit_mid,
    output logic [N-1:0]      mid_result,
    output logic [N-1:0]      down_result
);

    function automatic logic [N-1:0] process_row(
        input logic         md,
        input logic [N-1:0] m,
        input logic [N-1:0] u_in,
        input logic [N-1:0] c_in,
        input logic [N-1:0] d_in
    );
        logic [N-1:0] c;
        logic [N-1:0] from_left;
        logic [N-1:0] from_right;
        logic [N-1:0] all_set;
        c          = c_in & m;
        from_left  = (c << 1) & m;
        from_right = c >> 1;
        all_set    = (u_in & m) & (d_in & m) & from_left & from_right;
        if (md == beor_pkg::MODE_BORDER)
            process_row = c & ~all_set & m;
        else
            process_row = c & all_set & m;
    endfunction

    // Pending row: above, pending, new row below
    assign mid_result = process_row(mode, mask, up_row, mid_row, down_row);

    // Bottom row: the row above is the pending row if one was waiting; below is clear
    assign down_result = process_row(mode, mask, emit_mid ? mid_row : up_row,
                                     down_row, {N{1'b0}});

endmodule

`default_nettype wire

// ===== src/beor_out_fifo.sv =====
// Small result queue that takes up to two results per cycle and returns one per cycle when popped.
// Uses beor_pkg for the result type and queue geometry.
`timescale 1ns / 1ps
`default_nettype none

module beor_out_fifo (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [1:0]                 push_count,
    input  wire beor_pkg::out_item_t        push_first,
    input  wire beor_pkg::out_item_t        push_second,
    input  wire logic                       pop,
    output logic [beor_pkg::CNT_W-1:0]      free_slots,
    output logic                            head_valid,
    output beor_pkg::out_item_t             head_item
);

    beor_pkg::out_item_t               mem [beor_pkg::FIFO_DEPTH];
    logic [beor_pkg::PTR_W-1:0]        wr_ptr_reg;
    logic [beor_pkg::PTR_W-1:0]        wr_ptr_next;
    logic [beor_pkg::PTR_W-1:0]        rd_ptr_reg;
    logic [beor_pkg::PTR_W-1:0]        rd_ptr_next;
    logic [beor_pkg::CNT_W-1:0]        count_reg;
    logic [beor_pkg::CNT_W-1:0]        count_next;
    logic                              do_pop;
    logic [beor_pkg::PTR_W-1:0]        wr_ptr_plus1;

    assign do_pop       = pop && (count_reg != '0);
    assign wr_ptr_plus1 = wr_ptr_reg + beor_pkg::PTR_W'(1);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + beor_pkg::PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + beor_pkg::PTR_W'(do_pop);
        count_next  = count_reg + beor_pkg::CNT_W'(push_count)
                      - beor_pkg::CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming results in transfer order
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem[wr_ptr_reg] <= push_first;
        if (push_count == 2'd2)
            mem[wr_ptr_plus1] <= push_second;
    end

    assign free_slots = beor_pkg::CNT_W'(beor_pkg::FIFO_DEPTH) - count_reg;
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== tb/binary_erode_or_border_rows_unit_test.sv =====
// Self-checking testbench for binary_erode_or_border_rows_unit: directed and random images,
// predicted row by row and compared against every output transfer.
// Depends on beor_pkg and binary_erode_or_border_rows_unit.
`timescale 1ns / 1ps

module binary_erode_or_border_rows_unit_test;

    localparam int MAX_ROW_W       = 64;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 60;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int RANDOM_PHASES   = 11;
    localparam longint TIMEOUT_NS  = 10_000_000;

    // Pixel fill patterns for generated rows
    typedef enum int {
        ROWS_RANDOM,
        ROWS_DENSE,
        ROWS_FULL,
        ROWS_SPARSE
    } row_fill_t;

    // Receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_MOSTLY,
        RX_PERIODIC
    } stall_style_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [beor_pkg::IDX_W-1:0]     cfg_index = '0;
    logic [beor_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    beor_pkg::in_item_t             in_data   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    beor_pkg::out_item_t            out_data;

    // Image tracking and configuration copy
    logic                           cfg_mode      = beor_pkg::MODE_ERODE;
    logic [beor_pkg::WIDTH_W-1:0]   cfg_row_width = beor_pkg::RESET_ROW_WIDTH;
    logic [beor_pkg::PIX_W-1:0]     pending_row   = '0;
    logic [beor_pkg::PIX_W-1:0]     above_row     = '0;
    bit                             pending_valid = 1'b0;
    bit                             above_valid   = 1'b0;
    beor_pkg::out_item_t            expected_rows[$];
    int                             mismatch_count = 0;

    // Sender state
    bit                   offering      = 1'b0;
    bit                   sender_steady = 1'b0;
    int                   burst_left    = 0;

    // Receiver state
    int                   hold_requests = 0;
    int                   holds_served  = 0;
    int                   hold_left     = 0;
    int                   style_left    = 0;
    int                   rx_cycle      = 0;
    stall_style_t         rx_style      = RX_ALWAYS;

    binary_erode_or_border_rows_unit #(
        .MAX_ROW_WIDTH(MAX_ROW_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // Mask of the pixels in use; out-of-range widths are clamped
    function automatic logic [beor_pkg::PIX_W-1:0] active_mask();
        int w = int'(cfg_row_width);
        if (w < 1)
            w = 1;
        if (w > MAX_ROW_W)
            w = MAX_ROW_W;
        if (w >= beor_pkg::PIX_W)
            return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    // Cross-window result for one row given its vertical neighbours
    function automatic logic [beor_pkg::PIX_W-1:0] window_result(
        logic [beor_pkg::PIX_W-1:0] up,
        logic [beor_pkg::PIX_W-1:0] mid,
        logic [beor_pkg::PIX_W-1:0] down
    );
        logic [beor_pkg::PIX_W-1:0] m;
        logic [beor_pkg::PIX_W-1:0] c;
        logic [beor_pkg::PIX_W-1:0] all_set;
        m = active_mask();
        c = mid & m;
        all_set = (up & m) & (down & m) & ((c << 1) & m) & (c >> 1);
        if (cfg_mode == beor_pkg::MODE_BORDER)
            return c & ~all_set & m;
        return c & all_set & m;
    endfunction

    // Advance the image state by one accepted row and queue the rows it completes
    function automatic void advance_image(beor_pkg::in_item_t item);
        logic [beor_pkg::PIX_W-1:0] row;
        beor_pkg::out_item_t        res;
        row = item.row_pixels & active_mask();
        if (pending_valid)
        begin
            res.row_result = window_result(above_valid ? above_row : '0, pending_row, row);
            res.final_row  = 1'b0;
            expected_rows  = {expected_rows, res};
            above_row   = pending_row;
            above_valid = 1'b1;
        end
        pending_row   = row;
        pending_valid = 1'b1;
        if (item.last_row)
        begin
            res.row_result = window_result(above_valid ? above_row : '0, pending_row, '0);
            res.final_row  = 1'b1;
            expected_rows  = {expected_rows, res};
            pending_row   = '0;
            above_row     = '0;
            pending_valid = 1'b0;
            above_valid   = 1'b0;
        end
    endfunction

    function automatic logic [beor_pkg::PIX_W-1:0] random_row(row_fill_t fill);
        logic [beor_pkg::PIX_W-1:0] a;
        logic [beor_pkg::PIX_W-1:0] b;
        logic [beor_pkg::PIX_W-1:0] c;
        a = {$urandom(), $urandom()};
        b = {$urandom(), $urandom()};
        c = {$urandom(), $urandom()};
        case (fill)
            ROWS_DENSE:  return a | b | c;
            ROWS_FULL:   return ($urandom_range(0, 1) == 1) ? '1
                                : ~(64'd1 << $urandom_range(0, 63));
            ROWS_SPARSE: return a & b & c;
            default:     return a;
        endcase
    endfunction

    // Write one configuration register; the block must be idle
    task automatic write_reg(beor_pkg::reg_index_t idx, logic [beor_pkg::CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_wr_en <= 1'b1;
        if (idx == beor_pkg::REG_MODE)
            cfg_mode = value[0];
        else
            cfg_row_width = value[beor_pkg::WIDTH_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one row and hold it until the transfer; valid stays up for the next row
    task automatic send_row(logic [beor_pkg::PIX_W-1:0] pixels, logic last);
        beor_pkg::in_item_t item;
        int                 gap;
        item.row_pixels = pixels;
        item.last_row   = last;
        if (!sender_steady && burst_left == 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(20, 60);
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 10);
                gap = $urandom_range(1, 6);
            end
            if (gap > 0 && offering)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        in_data  <= item;
        in_valid <= 1'b1;
        offering = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_image(item);
    endtask

    task automatic send_image(int height, row_fill_t fill);
        for (int r = 0; r < height; r++)
            send_row(random_row(fill), r == height - 1);
    endtask

    // Drop valid, drain all expected rows, then let the pipeline settle
    task automatic wait_idle();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset configuration: single-row image and a full 3-row image
    task automatic test_reset_defaults();
        send_row('1, 1'b1);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        wait_idle();
    endtask

    // Border mode with unused upper data bits set on the mode write
    task automatic test_border_mode();
        write_reg(beor_pkg::REG_MODE, {6'($urandom_range(1, 63)), beor_pkg::MODE_BORDER});
        send_row('1, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        send_row({$urandom(), $urandom()}, 1'b1);
        wait_idle();
    endtask

    // Row widths at and below the low end of the range, just under the top and beyond it
    task automatic test_width_extremes();
        write_reg(beor_pkg::REG_ROW_WIDTH, 7'd0);
        send_row('1, 1'b0);
        send_row({$urandom(), $urandom()}, 1'b1);
        wait_idle();
        write_reg(beor_pkg::REG_MODE, {6'd0, beor_pkg::MODE_ERODE});
        write_reg(beor_pkg::REG_ROW_WIDTH, 7'd1);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        wait_idle();
        write_reg(beor_pkg::REG_ROW_WIDTH, 7'd63);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        wait_idle();
        write_reg(beor_pkg::REG_MODE, {6'd0, beor_pkg::MODE_BORDER});
        write_reg(beor_pkg::REG_ROW_WIDTH, 7'd127);
        send_row('1, 1'b0);
        send_row({$urandom(), $urandom()}, 1'b0);
        send_row('1, 1'b1);
        wait_idle();
    endtask

    // Narrow the width between the first and last row of one image
    task automatic test_width_change_mid_image();
        write_reg(beor_pkg::REG_MODE, {6'd0, beor_pkg::MODE_ERODE});
        write_reg(beor_pkg::REG_ROW_WIDTH, 7'd64);
        send_row('1, 1'b0);
        wait_idle();
        write_reg(beor_pkg::REG_ROW_WIDTH, 7'd5);
        send_row('1, 1'b1);
        wait_idle();
    endtask

    // Hold off the receiver while rows keep coming so the input stalls
    task automatic test_output_backpressure();
        write_reg(beor_pkg::REG_MODE, {6'd0, beor_pkg::MODE_ERODE});
        write_reg(beor_pkg::REG_ROW_WIDTH, 7'd64);
        sender_steady = 1'b1;
        hold_requests <= hold_requests + 1;
        repeat (8) send_image(4, ROWS_DENSE);
        wait_idle();
        write_reg(beor_pkg::REG_MODE, {6'd0, beor_pkg::MODE_BORDER});
        write_reg(beor_pkg::REG_ROW_WIDTH, 7'd17);
        hold_requests <= hold_requests + 1;
        repeat (12) send_image($urandom_range(1, 2), ROWS_RANDOM);
        sender_steady = 1'b0;
        wait_idle();
    endtask

    // Random images over several configurations, extremes first
    task automatic test_random_images();
        logic [beor_pkg::WIDTH_W-1:0] fixed_widths [7] =
            '{7'd64, 7'd1, 7'd2, 7'd0, 7'd127, 7'd65, 7'd63};
        logic [beor_pkg::WIDTH_W-1:0] w;
        logic                         m;
        row_fill_t                    fill;
        int                           sent;
        int                           pick;
        int                           height;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            w = (p < 7) ? fixed_widths[p] : 7'($urandom_range(1, 64));
            m = (p < 7) ? p[0] : 1'($urandom_range(0, 1));
            write_reg(beor_pkg::REG_MODE, {6'($urandom_range(0, 63)), m});
            write_reg(beor_pkg::REG_ROW_WIDTH, w);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 15);
                if (pick < 3)
                    height = 1;
                else if (pick < 6)
                    height = 2;
                else if (pick < 14)
                    height = $urandom_range(3, 8);
                else
                    height = $urandom_range(9, 30);
                fill = row_fill_t'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1)
                    fill = ROWS_DENSE;
                send_image(height, fill);
                sent += height;
            end
            wait_idle();
        end
    endtask

    // Receiver: switch stall pattern now and then, serve hold-off requests
    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_left == 0 && holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (style_left == 0)
        begin
            rx_style   = stall_style_t'($urandom_range(0, 3));
            style_left = $urandom_range(40, 300);
        end
        style_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_ALWAYS:   out_ready <= 1'b1;
                RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY:   out_ready <= ($urandom_range(0, 7) != 0);
                default:     out_ready <= (rx_cycle % 3 != 0);
            endcase
        end
    end

    // Compare each output transfer with the oldest expected row
    always @(posedge clk)
    begin : check_rows
        beor_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("unexpected result: row_result %h final_row %b",
                       out_data.row_result, out_data.final_row);
                mismatch_count++;
            end
            else
            begin
                want = expected_rows.pop_front();
                if (out_data.row_result !== want.row_result)
                begin
                    $error("row_result: expected %h, actual %h",
                           want.row_result, out_data.row_result);
                    mismatch_count++;
                end
                if (out_data.final_row !== want.final_row)
                begin
                    $error("final_row: expected %b, actual %b",
                           want.final_row, out_data.final_row);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_border_mode();
        test_width_extremes();
        test_width_change_mid_image();
        test_output_backpressure();
        test_random_images();
        wait_idle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== binary_erode_or_border_rows_unit.f =====
src/beor_pkg.sv
src/beor_row_proc.sv
src/beor_out_fifo.sv
src/binary_erode_or_border_rows_unit.sv
tb/binary_erode_or_border_rows_unit_test.sv
